/* sv/tlbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table search package
// Shared sizes for the table search block and its checker.
// ----------------------------------------------------------------------------
package tlbs_pkg;

  localparam int unsigned TableDepth = 8;
  localparam int unsigned IdxW       = 3;         // entry index width
  localparam int unsigned CntW       = IdxW + 1;  // holds 0..TableDepth
  localparam int unsigned LinCmpW    = 4;
  localparam int unsigned BinCmpW    = 3;
  localparam int unsigned WordW      = 32;

  localparam logic [IdxW-1:0]    LastIdx  = IdxW'(TableDepth - 1);
  localparam logic [CntW-1:0]    DepthCnt = CntW'(TableDepth);
  localparam logic [IdxW-1:0]    FirstMid = IdxW'((TableDepth - 1) / 2);
  localparam logic [LinCmpW-1:0] LinMax   = LinCmpW'(TableDepth);
  localparam logic [BinCmpW-1:0] BinMax   = BinCmpW'($clog2(TableDepth) + 1);

  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeSearch = 1'b1;

endpackage
`default_nettype wire

/* sv/table_linear_and_binary_search_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table linear and binary search
// Eight-word signed table with a linear scan and a binary search per key.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge with start high and busy low. A load word
// (mode 0) writes one table entry at that edge, keeps busy low and gives no
// result, so the block stays free for the next word. A search word (mode 1)
// runs a linear scan and a binary search side by side, each on its own read
// port of the table memory (registered read). The linear scan
// reads one entry per cycle, up to the first match or through the full
// table when there is no match; the binary search makes one probe per
// cycle, at most 4. A search holds busy for the longer of the two.
// The result shows for exactly one cycle with result_valid_o high; the
// receiver cannot stall it, and a new word may be accepted in that same
// cycle. Entries never loaded since reset read as undefined. The binary
// search assumes ascending signed order; on an unsorted table it reports
// whatever its probe sequence finds.
// ----------------------------------------------------------------------------
module table_linear_and_binary_search_top
  import tlbs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode_i,
  input  wire logic [IdxW-1:0]     entry_index_i,
  input  wire logic signed [WordW-1:0] entry_value_i,
  input  wire logic signed [WordW-1:0] search_key_i,
  output logic                     result_valid_o,
  output logic                     linear_found_o,
  output logic [IdxW-1:0]          linear_index_o,
  output logic [LinCmpW-1:0]       linear_compares_o,
  output logic                     binary_found_o,
  output logic [IdxW-1:0]          binary_index_o,
  output logic [BinCmpW-1:0]       binary_compares_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic valid_q, valid_d;

  logic accept, load_acc, search_acc;

  // table memory, two read ports
  logic [WordW-1:0] mem_q [TableDepth];
  logic [WordW-1:0] lin_rd_q, bin_rd_q;

  logic [WordW-1:0] key_q, key_d;

  // linear scan state
  logic [IdxW-1:0] lin_addr_q, lin_addr_d;
  logic            lin_done_q, lin_done_d;
  logic            lin_found_q, lin_found_d;

  // binary search state: [lo, end) window, end exclusive
  logic [CntW-1:0]    lo_q, lo_d;
  logic [CntW-1:0]    end_q, end_d;
  logic [CntW-1:0]    mid_full;
  logic [IdxW-1:0]    mid_q, mid_d;
  logic               bin_done_q, bin_done_d;
  logic               bin_found_q, bin_found_d;
  logic [BinCmpW-1:0] bin_cnt_q, bin_cnt_d;

  assign accept     = start && !busy;
  assign load_acc   = accept && (mode_i == ModeLoad);
  assign search_acc = accept && (mode_i == ModeSearch);

  always_comb begin
    state_d     = state_q;
    valid_d     = 1'b0;
    key_d       = key_q;
    lin_addr_d  = lin_addr_q;
    lin_done_d  = lin_done_q;
    lin_found_d = lin_found_q;
    lo_d        = lo_q;
    end_d       = end_q;
    bin_done_d  = bin_done_q;
    bin_found_d = bin_found_q;
    bin_cnt_d   = bin_cnt_q;
    mid_full    = '0;
    mid_d       = mid_q;

    unique case (state_q)
      StIdle: begin
        if (search_acc) begin
          state_d     = StRun;
          key_d       = search_key_i;
          lin_addr_d  = '0;
          lin_done_d  = 1'b0;
          lin_found_d = 1'b0;
          lo_d        = '0;
          end_d       = DepthCnt;
          bin_done_d  = 1'b0;
          bin_found_d = 1'b0;
          bin_cnt_d   = '0;
          mid_d       = FirstMid;
        end
      end
      StRun: begin
        // linear: lin_rd_q holds entry lin_addr_q
        if (!lin_done_q) begin
          if (lin_rd_q == key_q) begin
            lin_done_d  = 1'b1;
            lin_found_d = 1'b1;
          end else if (lin_addr_q == LastIdx) begin
            lin_done_d  = 1'b1;
          end else begin
            lin_addr_d  = lin_addr_q + 1'b1;
          end
        end
        // binary: bin_rd_q holds entry mid_q
        if (!bin_done_q) begin
          bin_cnt_d = bin_cnt_q + 1'b1;
          if (bin_rd_q == key_q) begin
            bin_done_d  = 1'b1;
            bin_found_d = 1'b1;
          end else begin
            if ($signed(bin_rd_q) < $signed(key_q)) begin
              lo_d = {1'b0, mid_q} + 1'b1;
            end else begin
              end_d = {1'b0, mid_q};
            end
            if (lo_d >= end_d) begin
              bin_done_d = 1'b1;
            end else begin
              mid_full = lo_d + ((end_d - lo_d - 1'b1) >> 1);
              mid_d    = mid_full[IdxW-1:0];
            end
          end
        end
        if (lin_done_d && bin_done_d) begin
          state_d = StIdle;
          valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= 1'b0;
      lin_done_q  <= 1'b0;
      lin_found_q <= 1'b0;
      bin_done_q  <= 1'b0;
      bin_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      lin_done_q  <= lin_done_d;
      lin_found_q <= lin_found_d;
      bin_done_q  <= bin_done_d;
      bin_found_q <= bin_found_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    lin_addr_q <= lin_addr_d;
    lo_q       <= lo_d;
    end_q      <= end_d;
    mid_q      <= mid_d;
    bin_cnt_q  <= bin_cnt_d;
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mem_q[entry_index_i] <= entry_value_i;
    end
    lin_rd_q <= mem_q[lin_addr_d];
    bin_rd_q <= mem_q[mid_d];
  end

  assign busy           = (state_q == StRun);
  assign result_valid_o = valid_q;

  // working registers hold still through the strobe cycle
  assign linear_found_o    = lin_found_q;
  assign linear_index_o    = lin_found_q ? lin_addr_q : '0;
  assign linear_compares_o = lin_found_q ? ({1'b0, lin_addr_q} + 1'b1) : LinMax;
  assign binary_found_o    = bin_found_q;
  assign binary_index_o    = bin_found_q ? mid_q : '0;
  assign binary_compares_o = bin_cnt_q;

endmodule
`default_nettype wire

/* sv/tlbs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table search checker
// Port-level checks on the table search block, bound to the top level.
// ----------------------------------------------------------------------------
module tlbs_checker
  import tlbs_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    mode_i,
  input wire logic                    result_valid_o,
  input wire logic                    linear_found_o,
  input wire logic [IdxW-1:0]         linear_index_o,
  input wire logic [LinCmpW-1:0]      linear_compares_o,
  input wire logic                    binary_found_o,
  input wire logic [IdxW-1:0]         binary_index_o,
  input wire logic [BinCmpW-1:0]      binary_compares_o
);

  // a strobe is always followed by valid low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // loads give no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == ModeLoad) |=> !result_valid_o)
    else $error("result after a load word");

  // a result means the search has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  // linear count follows the hit position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && linear_found_o) |->
      (linear_compares_o == ({1'b0, linear_index_o} + 1'b1)))
    else $error("linear compare count does not match index");

  // probe counts stay within the search bounds; a miss reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (binary_compares_o != '0 && binary_compares_o <= BinMax &&
                        (binary_found_o || binary_index_o == '0)))
    else $error("binary probe count or index out of range");

endmodule

bind table_linear_and_binary_search_top tlbs_checker u_tlbs_checker (.*);
`default_nettype wire

/* dv/table_linear_and_binary_search_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search testbench
// Loads the eight-entry table and sends search keys. Each search result is
// checked against a local copy of the table, searched both ways in software.
// ----------------------------------------------------------------------------
module table_linear_and_binary_search_top_tb;
  import tlbs_pkg::*;

  // One search result, field for field as it shows on the ports.
  typedef struct packed {
    logic               lin_found;
    logic [IdxW-1:0]    lin_index;
    logic [LinCmpW-1:0] lin_cmp;
    logic               bin_found;
    logic [IdxW-1:0]    bin_index;
    logic [BinCmpW-1:0] bin_cmp;
  } search_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start         = 1'b0;
  logic                    mode_i        = ModeLoad;
  logic [IdxW-1:0]         entry_index_i = '0;
  logic signed [WordW-1:0] entry_value_i = '0;
  logic signed [WordW-1:0] search_key_i  = '0;
  logic                    busy;
  logic                    result_valid_o;
  logic                    linear_found_o;
  logic [IdxW-1:0]         linear_index_o;
  logic [LinCmpW-1:0]      linear_compares_o;
  logic                    binary_found_o;
  logic [IdxW-1:0]         binary_index_o;
  logic [BinCmpW-1:0]      binary_compares_o;

  // Local copy of the table, updated when a load word is accepted.
  logic signed [WordW-1:0] table_copy [TableDepth];
  search_result_t          pending_searches [$];

  int  items_sent = 0;
  int  n_loads    = 0;
  int  n_searches = 0;
  int  lin_hits   = 0;
  int  bin_hits   = 0;
  int  n_errors   = 0;
  bit  idle_on    = 1'b1;

  table_linear_and_binary_search_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode_i),
    .entry_index_i     (entry_index_i),
    .entry_value_i     (entry_value_i),
    .search_key_i      (search_key_i),
    .result_valid_o    (result_valid_o),
    .linear_found_o    (linear_found_o),
    .linear_index_o    (linear_index_o),
    .linear_compares_o (linear_compares_o),
    .binary_found_o    (binary_found_o),
    .binary_index_o    (binary_index_o),
    .binary_compares_o (binary_compares_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Both searches over the local table copy. The binary search compares in
  // signed order and keeps probing whatever the table holds, sorted or not.
  function automatic search_result_t predict_search(logic signed [WordW-1:0] key);
    search_result_t r;
    int i;
    int lo;
    int hi;
    int mid;
    r         = '0;
    r.lin_cmp = LinMax;
    for (i = 0; i < TableDepth; i++) begin
      if (!r.lin_found && table_copy[i] == key) begin
        r.lin_found = 1'b1;
        r.lin_index = IdxW'(i);
        r.lin_cmp   = LinCmpW'(i + 1);
      end
    end
    lo = 0;
    hi = TableDepth - 1;
    while (lo <= hi && !r.bin_found) begin
      mid       = lo + (hi - lo) / 2;
      r.bin_cmp = r.bin_cmp + 1'b1;
      if (table_copy[mid] == key) begin
        r.bin_found = 1'b1;
        r.bin_index = IdxW'(mid);
      end else if (table_copy[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // Mix of extremes, a narrow band around zero and full-range words.
  function automatic logic signed [WordW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(WordW-1){1'b0}}};
      1: return {1'b0, {(WordW-1){1'b1}}};
      2: return WordW'($urandom_range(0, 8)) - WordW'(4);
      default: return $urandom;
    endcase
  endfunction

  // Random idle burst after a word, only while idling is on.
  task automatic gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Drive one word and hold it until the block takes it; the expectation is
  // formed once busy is low after the accepting edge. start stays high into
  // the next word unless an idle burst drops it.
  task automatic send_word(input logic m, input logic [IdxW-1:0] idx,
                           input logic signed [WordW-1:0] val,
                           input logic signed [WordW-1:0] key);
    search_result_t r;
    start         <= 1'b1;
    mode_i        <= m;
    entry_index_i <= idx;
    entry_value_i <= val;
    search_key_i  <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (m == ModeLoad) begin
      table_copy[idx] = val;
      n_loads++;
    end else begin
      r = predict_search(key);
      pending_searches.push_back(r);
      n_searches++;
      lin_hits += r.lin_found;
      bin_hits += r.bin_found;
    end
    gap();
  endtask

  // Don't-care fields get random values so they toggle too.
  task automatic load_entry(input logic [IdxW-1:0] idx, input logic signed [WordW-1:0] val);
    send_word(ModeLoad, idx, val, rand_word());
  endtask

  task automatic search_for(input logic signed [WordW-1:0] key);
    send_word(ModeSearch, IdxW'($urandom), rand_word(), key);
  endtask

  // Sender holds off until every search result is back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_searches.size() != 0) @(posedge clk_i);
  endtask

  // Fresh ascending table; the narrow band gives runs of equal entries.
  task automatic load_sorted_table();
    logic signed [WordW-1:0] vals [TableDepth];
    logic signed [WordW-1:0] t;
    bit narrow;
    int i;
    int j;
    narrow = ($urandom_range(0, 2) == 0);
    for (i = 0; i < TableDepth; i++)
      vals[i] = narrow ? WordW'($urandom_range(0, 12)) - WordW'(6) : rand_word();
    for (i = 0; i < TableDepth - 1; i++) begin
      for (j = 0; j < TableDepth - 1 - i; j++) begin
        if (vals[j] > vals[j+1]) begin
          t         = vals[j];
          vals[j]   = vals[j+1];
          vals[j+1] = t;
        end
      end
    end
    for (i = 0; i < TableDepth; i++) load_entry(IdxW'(i), vals[i]);
  endtask

  // Keys: mostly table entries, some off by one, some anywhere.
  task automatic search_round(input int n);
    logic signed [WordW-1:0] k;
    int s;
    repeat (n) begin
      s = $urandom_range(0, 9);
      k = table_copy[$urandom_range(0, TableDepth - 1)];
      if (s >= 8) k = rand_word();
      else if (s == 7) k = k + 1;
      else if (s == 6) k = k - 1;
      search_for(k);
    end
  endtask

  // Ascending table that spans the full signed range, then hits at both
  // ends, a hit on the first midpoint and misses between entries.
  task automatic test_sorted_extremes();
    load_entry(0, 32'sh8000_0000);
    load_entry(1, -32'sd1000);
    load_entry(2, -32'sd1);
    load_entry(3, 32'sd0);
    load_entry(4, 32'sd1);
    load_entry(5, 32'sd1000);
    load_entry(6, 32'sh7fff_fffe);
    load_entry(7, 32'sh7fff_ffff);
    search_for(32'sh8000_0000);
    search_for(32'sh7fff_ffff);
    search_for(32'sd0);
    search_for(32'sd500);
    search_for(-32'sd2);
  endtask

  // Duplicates make the two searches land on different indexes, as does an
  // out-of-order copy of the largest value; a value gone is a miss.
  task automatic test_dup_and_unsorted();
    load_entry(4, 32'sd7);
    load_entry(5, 32'sd7);
    search_for(32'sd7);
    load_entry(0, 32'sh7fff_ffff);
    search_for(32'sh7fff_ffff);
    search_for(32'sh8000_0000);
  endtask

  // Random rounds: mostly a sorted reload then searches, sometimes a few
  // single overwrites that leave the table out of order. Idling is turned
  // on and off per round, and now and then the sender drains.
  task automatic test_random_rounds(input int item_goal);
    int k;
    while (items_sent < item_goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        load_sorted_table();
      end else begin
        repeat ($urandom_range(1, 3))
          load_entry(IdxW'($urandom), rand_word());
      end
      search_round($urandom_range(3, 10));
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // Closing stretch with start held high throughout.
  task automatic test_back_to_back(input int item_goal);
    idle_on = 1'b0;
    while (items_sent < item_goal) begin
      load_sorted_table();
      search_round($urandom_range(3, 10));
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // Result strobe sampled at the edge that ends its cycle.
  always @(posedge clk_i) begin : check_results
    search_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_searches.size() == 0) begin
        $display("%0t: result with no search pending, expected none actual %0h", $time,
                 {linear_found_o, linear_index_o, linear_compares_o,
                  binary_found_o, binary_index_o, binary_compares_o});
        n_errors++;
      end else begin
        want = pending_searches.pop_front();
        check_field("linear_found",    want.lin_found, linear_found_o);
        check_field("linear_index",    want.lin_index, linear_index_o);
        check_field("linear_compares", want.lin_cmp,   linear_compares_o);
        check_field("binary_found",    want.bin_found, binary_found_o);
        check_field("binary_index",    want.bin_index, binary_index_o);
        check_field("binary_compares", want.bin_cmp,   binary_compares_o);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed part writes every entry before the first search, so no
    // search ever reads an entry that was never loaded.
    test_sorted_extremes();
    wait_drained();
    test_dup_and_unsorted();
    test_random_rounds(820);
    test_back_to_back(900);

    // Drain, then allow a search's worth of cycles for stray strobes.
    wait_drained();
    repeat (12) @(posedge clk_i);

    $display("Sent %0d words: %0d loads, %0d searches (%0d linear hits, %0d binary hits).",
             items_sent, n_loads, n_searches, lin_hits, bin_hits);
    $display("Tables were sorted, with duplicates, and out of order; idle bursts and drains.");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #(64'd2_000_000);
    $display("%0t: timeout, %0d results outstanding", $time, pending_searches.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* table_linear_and_binary_search_top.f */
sv/tlbs_pkg.sv
sv/table_linear_and_binary_search_top.sv
sv/tlbs_checker.sv
dv/table_linear_and_binary_search_top_tb.sv
